// ===== rtl/srrc_pkg.sv =====
`default_nettype none

package srrc_pkg;

    localparam int MAX_SWITCHES  = 8;
    localparam int SLOT_W        = $clog2(MAX_SWITCHES);
    localparam int BACKLOG_DEPTH = 16;
    localparam int BL_AW         = $clog2(BACKLOG_DEPTH);
    localparam int FILL_W        = BL_AW + 1;
    localparam int CNT_W         = 4;
    localparam int ADDR_W        = 32;
    localparam int ID_W          = 8;

    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_RULE = 1'b1;

    localparam logic ACT_DROP = 1'b0;
    localparam logic ACT_FWD  = 1'b1;

    localparam logic [1:0] PORT_NONE   = 2'd0;
    localparam logic [1:0] PORT_LOWER  = 2'd1;
    localparam logic [1:0] PORT_HIGHER = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic              clear;
        logic              issue;
        logic [SLOT_W-1:0] addr;
    } scan_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic              hit;
        logic [SLOT_W-1:0] idx;
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/srrc_table.sv =====
`default_nettype none

module srrc_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [srrc_pkg::SLOT_W-1:0] wr_slot,
    input  wire logic [srrc_pkg::ID_W-1:0]   wr_ident,
    input  wire logic [srrc_pkg::ADDR_W-1:0] wr_low,
    input  wire logic [srrc_pkg::ADDR_W-1:0] wr_high,
    input  wire srrc_pkg::scan_ctrl_t        ctrl,
    input  wire logic [srrc_pkg::ADDR_W-1:0] dest,
    output srrc_pkg::scan_res_t              res
);
    import srrc_pkg::*;

    logic [ID_W+2*ADDR_W-1:0] mem [MAX_SWITCHES];
    logic [2*ADDR_W-1:0]      rd_reg;
    logic                     pend_reg;
    logic [SLOT_W-1:0]        pend_idx_reg;
    logic                     hit_reg;
    logic [SLOT_W-1:0]        idx_reg;
    logic [ADDR_W-1:0]        low_reg;
    logic [ADDR_W-1:0]        high_reg;
    logic                     match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= {wr_ident, wr_high, wr_low};
        end
        if (ctrl.issue)
        begin
            rd_reg <= mem[ctrl.addr][2*ADDR_W-1:0];
        end
    end

    assign match = pend_reg && (dest >= rd_reg[ADDR_W-1:0])
                   && (dest <= rd_reg[2*ADDR_W-1:ADDR_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= ctrl.issue;
            if (ctrl.clear)
            begin
                hit_reg <= 1'b0;
            end
            else if (match)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= ctrl.addr;
        if (match)
        begin
            idx_reg  <= pend_idx_reg;
            low_reg  <= rd_reg[ADDR_W-1:0];
            high_reg <= rd_reg[2*ADDR_W-1:ADDR_W];
        end
    end

    assign res.busy = pend_reg;
    assign res.hit  = hit_reg;
    assign res.idx  = idx_reg;
    assign res.low  = low_reg;
    assign res.high = high_reg;

endmodule

`default_nettype wire

// ===== rtl/switch_range_rule_controller.sv =====
`default_nettype none

// Switch range rule controller. One request is taken at a time on the slave
// side (operation in tuser). An open request writes its table slot, counts
// one more opened switch and is acknowledged once the output register is free;
// the open that makes the count equal switch_count then answers every
// backlogged query in order. A query that arrives while switches are still
// missing is stored in the 16-entry backlog in the cycle it is taken (and
// dropped when the backlog is full); otherwise it is answered by a scan of
// the first min(switch_count,8) entries of the switch table memory, which
// gives one entry per cycle to the range compare. A finished reply waits in
// the master-side output register, so the next request can be taken
// meanwhile.
module switch_range_rule_controller (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [3:0]   cfg_wdata,      // switch_count
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // switch_slot, switch_ident, range_first, range_last, asker_number,
    // dest_address, zero pad
    input  wire logic [111:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // operation
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // reply_target, rule_low, rule_high, rule_action, rule_port, zero pad
    output logic [71:0]       m_axis_tdata,
    output logic              m_axis_tuser,   // reply_kind
    output logic              m_axis_tlast    // last_reply
);
    import srrc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ACK    = 3'd1;
    localparam logic [2:0] ST_BL_RD  = 3'd2;
    localparam logic [2:0] ST_BL_LD  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [SLOT_W-1:0] in_slot;
    logic [ID_W-1:0]   in_ident;
    logic [ADDR_W-1:0] in_first;
    logic [ADDR_W-1:0] in_last;
    logic [CNT_W-1:0]  in_asker;
    logic [ADDR_W-1:0] in_dest;

    assign in_slot  = s_axis_tdata[2:0];
    assign in_ident = s_axis_tdata[10:3];
    assign in_first = s_axis_tdata[42:11];
    assign in_last  = s_axis_tdata[74:43];
    assign in_asker = s_axis_tdata[78:75];
    assign in_dest  = s_axis_tdata[110:79];

    logic [2:0]         state_reg,  state_next;
    logic [CNT_W-1:0]   swcount_reg, swcount_next;
    logic [CNT_W-1:0]   opened_reg, opened_next;
    logic [FILL_W-1:0]  fill_reg,   fill_next;
    logic [BL_AW-1:0]   k_reg,      k_next;
    logic               drain_reg,  drain_next;
    logic               from_bl_reg, from_bl_next;
    logic [CNT_W-1:0]   issue_reg,  issue_next;
    logic [SLOT_W-1:0]  slot_reg,   slot_next;
    logic [CNT_W-1:0]   asker_reg,  asker_next;
    logic [ADDR_W-1:0]  dest_reg,   dest_next;

    logic               m_valid_reg, m_valid_next;
    logic               kind_reg,   kind_next;
    logic [SLOT_W-1:0]  target_reg, target_next;
    logic [ADDR_W-1:0]  low_reg,    low_next;
    logic [ADDR_W-1:0]  high_reg,   high_next;
    logic               action_reg, action_next;
    logic [1:0]         port_reg,   port_next;
    logic               last_reg,   last_next;

    logic [CNT_W+ADDR_W-1:0] bl_mem [BACKLOG_DEPTH];
    logic [CNT_W+ADDR_W-1:0] bl_rd_reg;
    logic                    bl_wr;
    logic                    bl_rd;

    logic        tbl_wr;
    scan_ctrl_t  scan_ctrl;
    scan_res_t   scan_res;

    logic [CNT_W-1:0] scan_limit;
    logic             out_free;
    logic             drain_end;
    logic [CNT_W-1:0] hit_num;

    srrc_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr),
        .wr_slot  (in_slot),
        .wr_ident (in_ident),
        .wr_low   (in_first),
        .wr_high  (in_last),
        .ctrl     (scan_ctrl),
        .dest     (dest_reg),
        .res      (scan_res)
    );

    assign scan_limit = (swcount_reg > CNT_W'(MAX_SWITCHES)) ? CNT_W'(MAX_SWITCHES)
                                                              : swcount_reg;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign drain_end  = (FILL_W'(k_reg) + FILL_W'(1)) == fill_reg;
    assign hit_num    = CNT_W'(scan_res.idx) + CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        swcount_next = cfg_we ? cfg_wdata : swcount_reg;
        opened_next  = opened_reg;
        fill_next    = fill_reg;
        k_next       = k_reg;
        drain_next   = drain_reg;
        from_bl_next = from_bl_reg;
        issue_next   = issue_reg;
        slot_next    = slot_reg;
        asker_next   = asker_reg;
        dest_next    = dest_reg;
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        target_next  = target_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        action_next  = action_reg;
        port_next    = port_reg;
        last_next    = last_reg;
        bl_wr        = 1'b0;
        bl_rd        = 1'b0;
        tbl_wr       = 1'b0;
        scan_ctrl    = '0;
        s_axis_tready = (state_reg == ST_IDLE);

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_OPEN)
                    begin
                        tbl_wr      = 1'b1;
                        opened_next = (opened_reg == COUNT_MAX) ? opened_reg
                                                                : opened_reg + CNT_W'(1);
                        drain_next  = (opened_next == swcount_reg);
                        slot_next   = in_slot;
                        state_next  = ST_ACK;
                    end
                    else if (opened_reg < swcount_reg)
                    begin
                        if (fill_reg < FILL_W'(BACKLOG_DEPTH))
                        begin
                            bl_wr     = 1'b1;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    else
                    begin
                        asker_next      = in_asker;
                        dest_next       = in_dest;
                        from_bl_next    = 1'b0;
                        issue_next      = '0;
                        scan_ctrl.clear = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_ACK;
                    target_next  = slot_reg;
                    low_next     = '0;
                    high_next    = '0;
                    action_next  = ACT_DROP;
                    port_next    = PORT_NONE;
                    last_next    = !(drain_reg && (fill_reg != '0));
                    if (drain_reg && (fill_reg != '0))
                    begin
                        k_next     = '0;
                        state_next = ST_BL_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BL_RD:
            begin
                bl_rd      = 1'b1;
                state_next = ST_BL_LD;
            end
            ST_BL_LD:
            begin
                asker_next      = bl_rd_reg[CNT_W-1:0];
                dest_next       = bl_rd_reg[CNT_W+ADDR_W-1:CNT_W];
                from_bl_next    = 1'b1;
                issue_next      = '0;
                scan_ctrl.clear = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue_reg < scan_limit)
                begin
                    scan_ctrl.issue = 1'b1;
                    scan_ctrl.addr  = issue_reg[SLOT_W-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                end
                else if (!scan_res.busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_RULE;
                    target_next  = asker_reg[SLOT_W-1:0] - SLOT_W'(1);
                    if (scan_res.hit)
                    begin
                        low_next    = scan_res.low;
                        high_next   = scan_res.high;
                        action_next = ACT_FWD;
                        port_next   = (hit_num < asker_reg) ? PORT_LOWER : PORT_HIGHER;
                    end
                    else
                    begin
                        low_next    = dest_reg;
                        high_next   = dest_reg;
                        action_next = ACT_DROP;
                        port_next   = PORT_NONE;
                    end
                    last_next = !from_bl_reg || drain_end;
                    if (from_bl_reg && !drain_end)
                    begin
                        k_next     = k_reg + BL_AW'(1);
                        state_next = ST_BL_RD;
                    end
                    else
                    begin
                        if (from_bl_reg)
                        begin
                            fill_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bl_wr)
        begin
            bl_mem[fill_reg[BL_AW-1:0]] <= {in_dest, in_asker};
        end
        if (bl_rd)
        begin
            bl_rd_reg <= bl_mem[k_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            swcount_reg <= CNT_W'(1);
            opened_reg  <= '0;
            fill_reg    <= '0;
            k_reg       <= '0;
            drain_reg   <= 1'b0;
            from_bl_reg <= 1'b0;
            issue_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            swcount_reg <= swcount_next;
            opened_reg  <= opened_next;
            fill_reg    <= fill_next;
            k_reg       <= k_next;
            drain_reg   <= drain_next;
            from_bl_reg <= from_bl_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        asker_reg  <= asker_next;
        dest_reg   <= dest_next;
        kind_reg   <= kind_next;
        target_reg <= target_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        action_reg <= action_next;
        port_reg   <= port_next;
        last_reg   <= last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {2'b00, port_reg, action_reg, high_reg, low_reg, target_reg};

endmodule

`default_nettype wire

// ===== dv/switch_range_rule_controller_tb.sv =====
`default_nettype none

module switch_range_rule_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import srrc_pkg::*;

    typedef struct {
        logic        op;
        logic [2:0]  slot;
        logic [7:0]  ident;
        logic [31:0] first;
        logic [31:0] last;
        logic [3:0]  asker;
        logic [31:0] dest;
    } request_t;

    typedef struct {
        logic        kind;
        logic [2:0]  target;
        logic [31:0] low;
        logic [31:0] high;
        logic        action;
        logic [1:0]  port;
        logic        last;
    } reply_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [3:0]   cfg_wdata = 4'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    request_t pending_q[$];
    request_t in_flight;
    reply_t   reply_q[$];
    request_t backlog_q[$];

    logic [31:0] tbl_low  [MAX_SWITCHES];
    logic [31:0] tbl_high [MAX_SWITCHES];
    logic [3:0]  open_cnt = 4'd0;
    logic [3:0]  sw_count = 4'd1;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int fail_cnt = 0;

    logic [31:0] probe_addr [17] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_1FFF, 32'h0000_1800,
        32'h0000_2FFF, 32'h0000_3000, 32'h0000_0FFF, 32'hFFFF_FF00, 32'h1234_5678,
        32'h0000_1900, 32'hFFFF_FEFF, 32'h0000_17FF, 32'h8000_0000, 32'h0000_2000,
        32'h7FFF_FFFF, 32'hFFFF_FF80
    };

    switch_range_rule_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic reply_t rule_for(input logic [3:0] asker, input logic [31:0] dest);
        reply_t rep;
        int     limit;
        int     hit;
        int     me;
        limit = (sw_count < MAX_SWITCHES) ? int'(sw_count) : MAX_SWITCHES;
        hit = -1;
        me = int'(asker) - 1;
        for (int j = 0; j < limit; j++)
        begin
            if (dest >= tbl_low[j] && dest <= tbl_high[j])
                hit = j;
        end
        rep.kind = KIND_RULE;
        rep.target = 3'(asker - 4'd1);
        rep.last = 1'b0;
        if (hit >= 0)
        begin
            rep.low = tbl_low[hit];
            rep.high = tbl_high[hit];
            rep.action = ACT_FWD;
            rep.port = (hit < me) ? PORT_LOWER : PORT_HIGHER;
        end
        else
        begin
            rep.low = dest;
            rep.high = dest;
            rep.action = ACT_DROP;
            rep.port = PORT_NONE;
        end
        return rep;
    endfunction

    task automatic predict_replies(input request_t r);
        reply_t batch[$];
        reply_t ack;
        if (r.op == OP_OPEN)
        begin
            tbl_low[r.slot] = r.first;
            tbl_high[r.slot] = r.last;
            if (open_cnt < COUNT_MAX)
                open_cnt++;
            ack.kind = KIND_ACK;
            ack.target = r.slot;
            ack.low = '0;
            ack.high = '0;
            ack.action = ACT_DROP;
            ack.port = PORT_NONE;
            ack.last = 1'b0;
            batch.push_back(ack);
            if (open_cnt == sw_count)
            begin
                foreach (backlog_q[k])
                    batch.push_back(rule_for(backlog_q[k].asker, backlog_q[k].dest));
                backlog_q.delete();
            end
        end
        else if (open_cnt < sw_count)
        begin
            if (backlog_q.size() < BACKLOG_DEPTH)
                backlog_q.push_back(r);
        end
        else
        begin
            batch.push_back(rule_for(r.asker, r.dest));
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            reply_q.push_back(batch[k]);
    endtask

    function automatic request_t open_req(input logic [2:0] slot, input logic [7:0] ident,
                                          input logic [31:0] first, input logic [31:0] last);
        request_t r;
        r.op = OP_OPEN;
        r.slot = slot;
        r.ident = ident;
        r.first = first;
        r.last = last;
        r.asker = 4'($urandom);
        r.dest = $urandom;
        return r;
    endfunction

    function automatic request_t query_req(input logic [3:0] asker, input logic [31:0] dest);
        request_t r;
        r.op = OP_QUERY;
        r.slot = 3'($urandom);
        r.ident = 8'($urandom);
        r.first = $urandom;
        r.last = $urandom;
        r.asker = asker;
        r.dest = dest;
        return r;
    endfunction

    function automatic request_t rand_open(input logic [2:0] slot);
        logic [31:0] a;
        logic [31:0] b;
        logic [32:0] top;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(7))
            0, 1:
            begin
            end
            2:
            begin
                if (a < b)
                begin
                    a = b;
                    b = a ^ b ^ b;
                end
                b = (a == 32'd0) ? 32'd0 : a - 32'd1 - 32'($urandom_range(255));
                if (b > a)
                    b = 32'd0;
            end
            3:
            begin
                a = 32'd0;
                b = 32'hFFFF_FFFF;
            end
            default:
            begin
                top = {1'b0, a} + 33'($urandom_range(4095));
                b = top[32] ? 32'hFFFF_FFFF : top[31:0];
            end
        endcase
        return open_req(slot, 8'($urandom), a, b);
    endfunction

    function automatic request_t rand_query();
        logic [3:0]  asker;
        logic [31:0] dest;
        int          j;
        j = $urandom_range(MAX_SWITCHES - 1);
        asker = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
        case ($urandom_range(5))
            0: dest = $urandom;
            1: dest = tbl_low[j];
            2: dest = tbl_high[j];
            3: dest = tbl_low[j] + 32'($urandom_range(2047));
            4: dest = tbl_low[j] - 32'd1;
            default: dest = tbl_high[j] + 32'd1;
        endcase
        return query_req(asker, dest);
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(input logic [3:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        sw_count = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n, input logic [3:0] count, input int gap,
                                input int stall);
        wait_idle();
        write_count(count);
        send_gap_pct = gap;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                wait_idle();
            if ($urandom_range(9) < 4)
                pending_q.push_back(rand_open(3'($urandom)));
            else
                pending_q.push_back(rand_query());
        end
    endtask

    task automatic report(input string field, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        $display("%0t: mismatch in %s: expected %h, actual %h", $time, field, exp_v, got_v);
        fail_cnt++;
    endtask

    // drive the slave side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_replies(in_flight);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_flight = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= in_flight.op;
                    s_axis_tdata <= {1'b0, in_flight.dest, in_flight.asker, in_flight.last,
                                     in_flight.first, in_flight.ident, in_flight.slot};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // drive the master-side ready and check replies
    always @(posedge clk)
    begin
        reply_t exp_r;
        reply_t got_r;
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r.kind = m_axis_tuser;
            got_r.target = m_axis_tdata[2:0];
            got_r.low = m_axis_tdata[34:3];
            got_r.high = m_axis_tdata[66:35];
            got_r.action = m_axis_tdata[67];
            got_r.port = m_axis_tdata[69:68];
            got_r.last = m_axis_tlast;
            if (reply_q.size() == 0)
            begin
                $display("%0t: unexpected reply: expected none, actual %h kind %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_cnt++;
            end
            else
            begin
                exp_r = reply_q.pop_front();
                if (got_r.kind !== exp_r.kind)
                    report("reply_kind", exp_r.kind, got_r.kind);
                if (got_r.target !== exp_r.target)
                    report("reply_target", exp_r.target, got_r.target);
                if (got_r.low !== exp_r.low)
                    report("rule_low", exp_r.low, got_r.low);
                if (got_r.high !== exp_r.high)
                    report("rule_high", exp_r.high, got_r.high);
                if (got_r.action !== exp_r.action)
                    report("rule_action", exp_r.action, got_r.action);
                if (got_r.port !== exp_r.port)
                    report("rule_port", exp_r.port, got_r.port);
                if (got_r.last !== exp_r.last)
                    report("last_reply", exp_r.last, got_r.last);
            end
        end
    end

    initial
    begin
        int          order [4];
        int          opens_left;
        int          pick;
        int          tmp;
        request_t    r;
        foreach (tbl_low[k])
        begin
            tbl_low[k] = '0;
            tbl_high[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_count(4'd4);

        // fill the backlog past its depth, then open slots 0 to 3
        for (int i = 0; i < 17; i++)
            pending_q.push_back(query_req(4'(i), probe_addr[i]));
        pending_q.push_back(open_req(3'd0, 8'h00, 32'h0000_1000, 32'h0000_1FFF));
        pending_q.push_back(open_req(3'd1, 8'hFF, 32'h0000_1800, 32'h0000_2FFF));
        pending_q.push_back(open_req(3'd2, 8'hA5, 32'hFFFF_FFFF, 32'h0000_0000));
        pending_q.push_back(open_req(3'd3, 8'h5A, 32'hFFFF_FF00, 32'hFFFF_FFFF));
        pending_q.push_back(query_req(4'd1, 32'h0000_1900));
        pending_q.push_back(query_req(4'd4, 32'h0000_1900));
        pending_q.push_back(query_req(4'd0, 32'h0000_1000));
        pending_q.push_back(query_req(4'd15, 32'hFFFF_FFFF));
        pending_q.push_back(query_req(4'd2, 32'h0000_5000));

        // backlog again until slots 4 to 7 open in random order
        wait_idle();
        write_count(4'd8);
        send_gap_pct = 48;
        order = '{4, 5, 6, 7};
        for (int k = 3; k > 0; k--)
        begin
            pick = $urandom_range(k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
        end
        opens_left = 4;
        for (int i = 0; i < 22; i++)
        begin
            if (opens_left > 0 && $urandom_range(21 - i) < opens_left)
            begin
                r = rand_open(3'(order[4 - opens_left]));
                opens_left--;
            end
            else
            begin
                r = rand_query();
            end
            pending_q.push_back(r);
        end

        random_phase(21, 4'd1, 0, 48);
        random_phase(21, 4'($urandom_range(7, 2)), 31, 31);
        random_phase(21, 4'd8, 0, 0);

        wait_idle();
        repeat (30) @(posedge clk);
        if (reply_q.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/srrc_pkg.sv
rtl/srrc_table.sv
rtl/switch_range_rule_controller.sv
dv/switch_range_rule_controller_tb.sv
